/* rtl/swrm_pkg.sv */
`default_nettype none

package swrm_pkg;

  // window geometry
  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // field widths
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned RATE_W  = 56;
  localparam int unsigned SLOT_W  = 2 * CNT32_W;

  // sums grow by the log of the depth
  localparam int unsigned SUM_W  = CNT32_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned US_W   = 20;
  localparam int unsigned PROD_W = SUM_W + US_W;
  localparam int unsigned DCNT_W = $clog2(PROD_W + 1);

  localparam logic [US_W-1:0]   US_PER_S  = US_W'(1000000);
  localparam logic [TIME_W-1:0] RATE_ONES = 64'h00FF_FFFF_FFFF_FFFF;
  // largest byte sum whose product with one million fits 64 bits
  localparam logic [TIME_W-1:0] MAX_BYTES = 64'd18446744073709;

  // stream packing
  localparam int unsigned IN_DATA_W  = 3 * CNT32_W + TIME_W;
  localparam int unsigned OUT_DATA_W = RATE_W + CNT32_W;
  localparam int unsigned OUT_USER_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/swrm_ram.sv */
`default_nettype none

module swrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/swrm_div.sv */
`default_nettype none

module swrm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [swrm_pkg::PROD_W-1:0]   dividend_i,
  input  wire logic [swrm_pkg::SUM_W-1:0]    divisor_i,
  output logic      [swrm_pkg::PROD_W-1:0]   quotient_o,
  output swrm_pkg::div_stat_t                stat_o
);

  logic [swrm_pkg::PROD_W-1:0] quo_q, quo_d;
  logic [swrm_pkg::SUM_W-1:0]  rem_q, rem_d;
  logic [swrm_pkg::SUM_W-1:0]  dvs_q;
  logic [swrm_pkg::DCNT_W-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [swrm_pkg::SUM_W:0]    rem_sh, rem_sub;
  logic                        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_q, quo_q[swrm_pkg::PROD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[swrm_pkg::SUM_W-1:0] : rem_sh[swrm_pkg::SUM_W-1:0];
    quo_d   = {quo_q[swrm_pkg::PROD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= swrm_pkg::DCNT_W'(swrm_pkg::PROD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - swrm_pkg::DCNT_W'(1);
      if (cnt_q == swrm_pkg::DCNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

/* rtl/sliding_window_rate_meter.sv */
// sequence: a beat taken in ST_IDLE passes ST_UPDATE, ST_CALC, ST_DIV (the serial
// divider, one bit per cycle) and ST_DONE, and the next beat is taken only back in ST_IDLE;
// a disabled beat goes straight to ST_DONE, and a zero time sum or a byte sum over
// MAX_BYTES goes from ST_CALC to ST_DONE, so both skip the divider;
// a result held back by the master side stalls the next beat in ST_DONE
// reset: asynchronous, active low; ring valid bits, sums, pointer and report time clear,
// enable comes up set and the report interval at zero; the ring needs no clearing pass
`default_nettype none

module sliding_window_rate_meter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // byte_count, duration_us, item_total, now_us (from bit 0)
  input  wire logic [swrm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // rate_bps, item_count_out (from bit 0)
  output logic      [swrm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // time_zero, report_due (from bit 0)
  output logic      [swrm_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [swrm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [swrm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic                               enable_q;
  logic [swrm_pkg::CNT32_W-1:0]       interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      interval_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swrm_pkg::REG_ENABLE:   enable_q   <= cfg_data_i[0];
        swrm_pkg::REG_INTERVAL: interval_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  swrm_pkg::state_e state_q, state_d;

  logic              in_beat;
  logic              out_free;
  logic              div_start;
  logic              calc_skip;
  swrm_pkg::div_stat_t div_stat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  // the result register is free, or empties at this very edge
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swrm_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_d = enable_q ? swrm_pkg::ST_UPDATE : swrm_pkg::ST_DONE;
        end
      end
      swrm_pkg::ST_UPDATE: state_d = swrm_pkg::ST_CALC;
      swrm_pkg::ST_CALC:   state_d = calc_skip ? swrm_pkg::ST_DONE : swrm_pkg::ST_DIV;
      swrm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = swrm_pkg::ST_DONE;
        end
      end
      swrm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = swrm_pkg::ST_IDLE;
        end
      end
      default: state_d = swrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      swrm_pkg::ST_IDLE: s_axis_tready = 1'b1;
      swrm_pkg::ST_CALC: div_start     = !calc_skip;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // captured beat
  // ---------------------------------------------------------------------------
  logic [swrm_pkg::CNT32_W-1:0] nb_q, nt_q;
  logic [swrm_pkg::TIME_W-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      nb_q  <= s_axis_tdata[31:0];
      nt_q  <= s_axis_tdata[63:32];
      now_q <= s_axis_tdata[159:96];
    end
  end

  // ---------------------------------------------------------------------------
  // ring of the last transfers: one memory entry per slot, {duration, bytes}
  // the read always runs at the slot pointer, so the old entry is ready in
  // the update cycle right after the beat is taken
  // ---------------------------------------------------------------------------
  logic [swrm_pkg::PTR_W-1:0]        ptr_q;
  logic [swrm_pkg::WINDOW_DEPTH-1:0] slot_vld_q;
  logic [swrm_pkg::SLOT_W-1:0]       ring_rdata;
  logic                              ring_we;
  logic [swrm_pkg::CNT32_W-1:0]      old_b, old_t;

  assign ring_we = (state_q == swrm_pkg::ST_UPDATE);

  swrm_ram #(
    .WIDTH (swrm_pkg::SLOT_W),
    .DEPTH (swrm_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i ({nt_q, nb_q}),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // a slot never written reads as zero
  assign old_b = slot_vld_q[ptr_q] ? ring_rdata[31:0]  : '0;
  assign old_t = slot_vld_q[ptr_q] ? ring_rdata[63:32] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      slot_vld_q <= '0;
    end else if (ring_we) begin
      slot_vld_q[ptr_q] <= 1'b1;
      if (ptr_q == swrm_pkg::PTR_W'(swrm_pkg::WINDOW_DEPTH - 1)) begin
        ptr_q <= '0;
      end else begin
        ptr_q <= ptr_q + swrm_pkg::PTR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // running sums and report timing
  // ---------------------------------------------------------------------------
  logic [swrm_pkg::SUM_W-1:0]  sum_b_q, sum_b_d;
  logic [swrm_pkg::SUM_W-1:0]  sum_t_q, sum_t_d;
  logic [swrm_pkg::TIME_W-1:0] last_rep_q;
  logic [swrm_pkg::TIME_W-1:0] elapsed;
  logic                        due;

  // the sum always holds the old slot, so no wrap below zero
  assign sum_b_d = sum_b_q - swrm_pkg::SUM_W'(old_b) + swrm_pkg::SUM_W'(nb_q);
  assign sum_t_d = sum_t_q - swrm_pkg::SUM_W'(old_t) + swrm_pkg::SUM_W'(nt_q);

  // a clock running backwards counts as no time elapsed
  assign elapsed = (now_q >= last_rep_q) ? (now_q - last_rep_q) : '0;
  assign due     = elapsed >= swrm_pkg::TIME_W'(interval_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_b_q    <= '0;
      sum_t_q    <= '0;
      last_rep_q <= '0;
    end else if (state_q == swrm_pkg::ST_UPDATE) begin
      sum_b_q <= sum_b_d;
      sum_t_q <= sum_t_d;
      if (due) begin
        last_rep_q <= now_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rate: bytes times one million, then a serial divide by the time sum
  // ---------------------------------------------------------------------------
  logic                          time_zero;
  logic                          bytes_big;
  logic [swrm_pkg::PROD_W-1:0]   product;
  logic [swrm_pkg::PROD_W-1:0]   quotient;
  logic [swrm_pkg::TIME_W-1:0]   quo_wide;
  logic [swrm_pkg::RATE_W-1:0]   rate_sat;

  assign time_zero = (sum_t_q == '0);
  assign bytes_big = swrm_pkg::TIME_W'(sum_b_q) > swrm_pkg::MAX_BYTES;
  assign calc_skip = time_zero || bytes_big;
  assign product   = swrm_pkg::PROD_W'(sum_b_q) * swrm_pkg::PROD_W'(swrm_pkg::US_PER_S);

  swrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (sum_t_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign quo_wide = swrm_pkg::TIME_W'(quotient);
  assign rate_sat = (quo_wide > swrm_pkg::RATE_ONES) ? swrm_pkg::RATE_ONES[swrm_pkg::RATE_W-1:0]
                                                     : quo_wide[swrm_pkg::RATE_W-1:0];

  // ---------------------------------------------------------------------------
  // result fields, built up while the beat is worked on
  // ---------------------------------------------------------------------------
  logic [swrm_pkg::RATE_W-1:0]  res_rate_q;
  logic                         res_zero_q;
  logic                         res_due_q;
  logic [swrm_pkg::CNT32_W-1:0] res_total_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      // a disabled beat gives an all-zero result
      res_rate_q  <= '0;
      res_zero_q  <= 1'b0;
      res_due_q   <= 1'b0;
      res_total_q <= enable_q ? s_axis_tdata[95:64] : '0;
    end else if (state_q == swrm_pkg::ST_UPDATE) begin
      res_due_q <= due;
    end else if (state_q == swrm_pkg::ST_CALC) begin
      if (calc_skip) begin
        res_rate_q <= swrm_pkg::RATE_ONES[swrm_pkg::RATE_W-1:0];
        res_zero_q <= time_zero;
      end
    end else if (state_q == swrm_pkg::ST_DIV && div_stat.done) begin
      res_rate_q <= rate_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: lets the sequencer move on while a result waits
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_q == swrm_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {res_total_q, res_rate_q};
      m_axis_tuser <= {res_due_q, res_zero_q};
    end
  end

endmodule

`default_nettype wire

/* verif/sliding_window_rate_meter_test.sv */
`timescale 1ns / 1ps

module sliding_window_rate_meter_test;

  // beat latency of the serial divider plus a margin for the quiet pauses
  localparam int unsigned SETTLE_CYCLES = swrm_pkg::PROD_W + 12;
  // cycles without any beat on any channel before the run is called hung
  localparam int unsigned STALL_LIMIT   = 4000;
  // percentage of cycles in which either side holds back
  localparam int unsigned IDLE_PCT      = 19;

  // register index that the block does not decode
  localparam logic [swrm_pkg::CFG_IDX_W-1:0] REG_SPARE = swrm_pkg::CFG_IDX_W'(9);

  localparam logic [swrm_pkg::TIME_W-1:0] RATE_MAX    = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [swrm_pkg::TIME_W-1:0] MICROS      = 64'd1000000;
  // largest byte sum whose product with one million still fits 64 bits
  localparam logic [swrm_pkg::TIME_W-1:0] BYTES_LIMIT = 64'd18446744073709;

  // one transfer record as offered on the slave side
  typedef struct {
    logic [swrm_pkg::CNT32_W-1:0] nbytes;
    logic [swrm_pkg::CNT32_W-1:0] dur_us;
    logic [swrm_pkg::CNT32_W-1:0] total;
    logic [swrm_pkg::TIME_W-1:0]  now_us;
    bit                           hold;    // wait for every outstanding report first
  } transfer_t;

  // one throughput report as seen on the master side
  typedef struct {
    logic [swrm_pkg::RATE_W-1:0]  rate;
    logic                         zero;
    logic [swrm_pkg::CNT32_W-1:0] count;
    logic                         due;
  } report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // byte_count, duration_us, item_total, now_us (from bit 0)
  logic [swrm_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // rate_bps, item_count_out (from bit 0)
  logic [swrm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // time_zero, report_due (from bit 0)
  logic [swrm_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  sliding_window_rate_meter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // transfers waiting to be offered, and reports still owed by the block
  transfer_t transfer_q[$];
  report_t   owed_reports[$];

  // own copy of the meter: ring, pointer, running sums, last strobe time
  logic [swrm_pkg::CNT32_W-1:0] win_bytes [swrm_pkg::WINDOW_DEPTH];
  logic [swrm_pkg::CNT32_W-1:0] win_time  [swrm_pkg::WINDOW_DEPTH];
  int unsigned                  slot_idx       = 0;
  logic [swrm_pkg::TIME_W-1:0]  sum_bytes      = '0;
  logic [swrm_pkg::TIME_W-1:0]  sum_time       = '0;
  logic [swrm_pkg::TIME_W-1:0]  last_strobe_us = '0;
  logic                         cfg_enable     = 1'b1;
  logic [swrm_pkg::CNT32_W-1:0] cfg_interval   = '0;

  transfer_t   on_bus;
  report_t     fresh_report;
  report_t     want;
  bit          calm         = 1'b0;   // no back-pressure and no gaps on either side
  int unsigned stall_cycles = 0;
  int unsigned fail_cnt     = 0;
  int unsigned sent_cnt     = 0;
  int unsigned checked_cnt  = 0;
  int unsigned off_cnt      = 0;
  int unsigned zero_cnt     = 0;
  int unsigned due_cnt      = 0;
  int unsigned cfg_cnt      = 0;
  logic [swrm_pkg::TIME_W-1:0]  now_cursor   = '0;
  logic [swrm_pkg::CNT32_W-1:0] total_cursor = '0;

  initial begin
    for (int i = 0; i < swrm_pkg::WINDOW_DEPTH; i++) begin
      win_bytes[i] = '0;
      win_time[i]  = '0;
    end
  end

  // window update and rate for one accepted transfer
  task automatic rate_after(input transfer_t t, output report_t r);
    logic [swrm_pkg::TIME_W-1:0] elapsed;
    logic [swrm_pkg::TIME_W-1:0] quot;
    r = '{rate: '0, zero: 1'b0, count: '0, due: 1'b0};
    if (!cfg_enable) begin
      // disabled: state untouched, all-zero report
      off_cnt++;
    end else begin
      sum_bytes = sum_bytes - swrm_pkg::TIME_W'(win_bytes[slot_idx])
                  + swrm_pkg::TIME_W'(t.nbytes);
      sum_time  = sum_time  - swrm_pkg::TIME_W'(win_time[slot_idx])
                  + swrm_pkg::TIME_W'(t.dur_us);
      win_bytes[slot_idx] = t.nbytes;
      win_time[slot_idx]  = t.dur_us;
      slot_idx = (slot_idx == swrm_pkg::WINDOW_DEPTH - 1) ? 0 : slot_idx + 1;

      if (sum_time == '0) begin
        // empty time window saturates the rate
        r.rate = '1;
        r.zero = 1'b1;
        zero_cnt++;
      end else if (sum_bytes > BYTES_LIMIT) begin
        r.rate = '1;
      end else begin
        quot   = (sum_bytes * MICROS) / sum_time;
        r.rate = (quot > RATE_MAX) ? '1 : quot[swrm_pkg::RATE_W-1:0];
      end

      // a clock going backwards counts as no time elapsed
      elapsed = (t.now_us >= last_strobe_us) ? t.now_us - last_strobe_us : '0;
      r.due   = (elapsed >= swrm_pkg::TIME_W'(cfg_interval));
      if (r.due) begin
        last_strobe_us = t.now_us;
        due_cnt++;
      end
      r.count = t.total;
    end
  endtask

  // slave-side driver: predicts on every accepted beat, then offers the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rate_after(on_bus, fresh_report);
        owed_reports.push_back(fresh_report);
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (transfer_q.size() != 0 &&
            !(transfer_q[0].hold && owed_reports.size() != 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = transfer_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.now_us, on_bus.total, on_bus.dur_us, on_bus.nbytes};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // master-side monitor: checks each report beat against the oldest one owed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cycles  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_reports.size() == 0) begin
          $error("report beat with no transfer outstanding");
          fail_cnt++;
        end else begin
          want = owed_reports.pop_front();
          checked_cnt++;
          if (m_axis_tdata[swrm_pkg::RATE_W-1:0] !== want.rate) begin
            $error("rate_bps: expected %0h, got %0h", want.rate,
                   m_axis_tdata[swrm_pkg::RATE_W-1:0]);
            fail_cnt++;
          end
          if (m_axis_tuser[0] !== want.zero) begin
            $error("time_zero: expected %0b, got %0b", want.zero, m_axis_tuser[0]);
            fail_cnt++;
          end
          if (m_axis_tdata[swrm_pkg::RATE_W +: swrm_pkg::CNT32_W] !== want.count) begin
            $error("item_count_out: expected %0h, got %0h", want.count,
                   m_axis_tdata[swrm_pkg::RATE_W +: swrm_pkg::CNT32_W]);
            fail_cnt++;
          end
          if (m_axis_tuser[1] !== want.due) begin
            $error("report_due: expected %0b, got %0b", want.due, m_axis_tuser[1]);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      // any beat on any channel counts as progress
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // hang detector
  initial begin
    wait (rst_ni);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // register write, only ever issued while the block is quiet
  task automatic write_reg(input logic [swrm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swrm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_cnt++;
    if (idx == swrm_pkg::REG_ENABLE)
      cfg_enable = val[0];
    else if (idx == swrm_pkg::REG_INTERVAL)
      cfg_interval = val;
  endtask

  // drain everything and let the divider fall quiet
  task automatic settle();
    while (transfer_q.size() != 0 || s_axis_tvalid || owed_reports.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_transfer(input logic [swrm_pkg::CNT32_W-1:0] nb,
                                input logic [swrm_pkg::CNT32_W-1:0] dur,
                                input logic [swrm_pkg::CNT32_W-1:0] tot,
                                input logic [swrm_pkg::TIME_W-1:0]  now,
                                input bit hold);
    transfer_t t;
    t.nbytes = nb;
    t.dur_us = dur;
    t.total  = tot;
    t.now_us = now;
    t.hold   = hold;
    transfer_q.push_back(t);
  endtask

  // mostly well-formed traffic with a rising clock, plus idle-time runs and noise
  task automatic queue_traffic(input int unsigned n);
    int unsigned k;
    int unsigned roll;
    logic [swrm_pkg::CNT32_W-1:0] nb;
    logic [swrm_pkg::CNT32_W-1:0] dur;
    logic [swrm_pkg::TIME_W-1:0]  now;
    k = 0;
    while (k < n) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        // a run of zero-length transfers long enough to empty the time window
        for (int j = 0; j < swrm_pkg::WINDOW_DEPTH + 1; j++) begin
          total_cursor++;
          now_cursor += swrm_pkg::TIME_W'($urandom_range(0, 200));
          queue_transfer($urandom, '0, total_cursor, now_cursor, 1'b0);
        end
        k += swrm_pkg::WINDOW_DEPTH + 1;
      end else if (roll < 88) begin
        nb  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535);
        if ($urandom_range(19) == 0)
          dur = '0;
        else if ($urandom_range(9) == 0)
          dur = $urandom;
        else
          dur = $urandom_range(1, 5000);
        total_cursor++;
        now_cursor += swrm_pkg::TIME_W'($urandom_range(0, 3000));
        queue_transfer(nb, dur, total_cursor, now_cursor, $urandom_range(99) == 0);
        k++;
      end else begin
        // noise: wild counts, clock jumps back or to anywhere
        if ($urandom_range(1) == 0) begin
          now = now_cursor - swrm_pkg::TIME_W'($urandom_range(1, 5000));
        end else begin
          now        = {$urandom, $urandom};
          now_cursor = now;
        end
        queue_transfer($urandom, $urandom, $urandom, now, 1'b0);
        k++;
      end
    end
  endtask

  task automatic traffic_phase(input logic en, input logic [swrm_pkg::CNT32_W-1:0] ival,
                               input int unsigned n);
    settle();
    write_reg(swrm_pkg::REG_ENABLE, swrm_pkg::CFG_DATA_W'(en));
    write_reg(swrm_pkg::REG_INTERVAL, ival);
    queue_traffic(n);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults written explicitly; a spare index must not touch enable
    write_reg(swrm_pkg::REG_ENABLE, 32'd1);
    write_reg(swrm_pkg::REG_INTERVAL, 32'd0);
    write_reg(REG_SPARE, 32'd0);
    // empty time window, with and without bytes
    queue_transfer('0, '0, '0, 64'd0, 1'b0);
    queue_transfer('1, '0, '1, 64'd1, 1'b0);
    // huge bytes over a single microsecond, sent once the block has caught up
    queue_transfer('1, 32'd1, 32'd2, 64'd2, 1'b1);
    queue_transfer(32'd1, '1, 32'd3, '1, 1'b0);
    // clock steps back, still a strobe with a zero interval
    queue_transfer(32'd1500, 32'd7, 32'd4, 64'd5, 1'b0);

    settle();
    write_reg(swrm_pkg::REG_INTERVAL, 32'd1000);
    queue_transfer(32'd100, 32'd10, 32'd5, 64'd100, 1'b0);    // too soon
    queue_transfer(32'd200, 32'd20, 32'd6, 64'd1005, 1'b0);   // exactly one interval
    queue_transfer(32'd300, 32'd30, 32'd7, 64'd2004, 1'b0);   // one short
    queue_transfer(32'd400, 32'd40, 32'd8, 64'd500, 1'b0);    // clock going back
    queue_transfer(32'h8000_0000, 32'h8000_0000, 32'd9, '1, 1'b0);

    settle();
    write_reg(swrm_pkg::REG_ENABLE, 32'd0);
    queue_transfer('1, '1, '1, '1, 1'b0);
    queue_transfer(32'h5a5a_5a5a, 32'd3, 32'h1234_5678, 64'd77, 1'b0);

    settle();
    write_reg(swrm_pkg::REG_ENABLE, 32'd1);
    write_reg(swrm_pkg::REG_INTERVAL, '1);
    queue_transfer(32'd10, 32'd1, 32'd10, '1, 1'b0);
    queue_transfer(32'd20, 32'd2, 32'd11, 64'd0, 1'b0);
    queue_transfer('1, '1, '1, 64'd3, 1'b0);

    // random traffic across several settings
    traffic_phase(1'b1, 32'd0, 200);
    traffic_phase(1'b1, $urandom_range(1, 3000), 200);
    traffic_phase(1'b0, $urandom, 40);
    traffic_phase(1'b1, '1, 100);
    traffic_phase(1'b1, $urandom, 200);

    // a long stretch with both sides always willing
    settle();
    calm = 1'b1;
    write_reg(swrm_pkg::REG_ENABLE, 32'd1);
    write_reg(swrm_pkg::REG_INTERVAL, $urandom_range(0, 500));
    queue_traffic(250);
    settle();
    calm = 1'b0;

    $display("sent %0d transfers (%0d while disabled) over %0d register writes",
             sent_cnt, off_cnt, cfg_cnt);
    $display("checked %0d reports: %0d with an empty time window, %0d report strobes",
             checked_cnt, zero_cnt, due_cnt);
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
